### hw/rtl/aess_pkg.sv
`default_nettype none
package aess_pkg;

  // activity levels 0, 80, 160, 240, 320, 400 held as codes 0..5
  localparam int LEVEL_W = 3;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t LVL_ZERO = 3'd0;
  localparam level_t LVL_LOW  = 3'd1;
  localparam level_t LVL_TOP  = 3'd5;

  typedef enum logic [1:0] {
    STAGE_ACTIVE  = 2'd0,
    STAGE_SHALLOW = 2'd1,
    STAGE_DEEP    = 2'd2
  } stage_t;

  // one level moving between passes; last closes the day
  typedef struct packed {
    level_t level;
    logic   last;
  } token_t;

endpackage
`default_nettype wire

### hw/rtl/aess_front.sv
`default_nettype none
module aess_front import aess_pkg::*; #(
  parameter int MAX_EPOCHS    = 256,
  parameter int ACTIVITY_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ACTIVITY_BITS-1:0] activity,
  input  wire logic                     last,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  output token_t                        out_tok,
  output logic                          out_valid,
  input  wire logic                     out_ready
);

  localparam int TAKEN_W = $clog2(MAX_EPOCHS);
  localparam logic [TAKEN_W-1:0] TAKEN_LAST = TAKEN_W'(MAX_EPOCHS - 1);

  localparam logic [31:0] TH_320 = 32'd320;
  localparam logic [31:0] TH_240 = 32'd240;
  localparam logic [31:0] TH_160 = 32'd160;
  localparam logic [31:0] TH_80  = 32'd80;

  logic [TAKEN_W-1:0] taken;
  level_t             w0;
  level_t             w1;
  logic               v0;
  logic               v1;
  logic               drain;

  logic [31:0] act_wide;
  level_t      x;
  level_t      c;
  logic        fin;
  logic        accept;
  logic        out_free;
  logic        drain_go;

  function automatic level_t lift(input level_t lv);
    return (lv > LVL_LOW) ? LVL_TOP : lv;
  endfunction

  assign act_wide = 32'(activity);

  always_comb begin
    if (act_wide >= TH_320) begin
      x = 3'd5;
    end else if (act_wide >= TH_240) begin
      x = 3'd4;
    end else if (act_wide >= TH_160) begin
      x = 3'd3;
    end else if (act_wide > TH_80) begin
      x = 3'd2;
    end else if (act_wide != 32'd0) begin
      x = LVL_LOW;
    end else begin
      x = LVL_ZERO;
    end
  end

  // dip smoothing: w0 is the already smoothed previous level, x the next one
  always_comb begin
    c = w1;
    if (v0) begin
      if (w0 == x && w1 < w0) begin
        c = w0;
      end else if (w0 == x + 3'd1 && w1 < x) begin
        c = x;
      end else if (x == w0 + 3'd1 && w1 < w0) begin
        c = w0;
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = !drain && out_free;
  assign accept   = in_valid && in_ready;
  assign drain_go = drain && out_free;
  assign fin      = last || (taken == TAKEN_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      taken     <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        taken <= fin ? '0 : taken + 1'b1;
        if (v1) begin
          out_tok   <= '{level: lift(c), last: 1'b0};
          out_valid <= 1'b1;
          w0        <= c;
          v0        <= 1'b1;
        end
        w1    <= x;
        v1    <= 1'b1;
        drain <= fin;
      end else if (drain_go) begin
        // the day's final epoch goes out unsmoothed
        out_tok   <= '{level: lift(w1), last: 1'b1};
        out_valid <= 1'b1;
        v0        <= 1'b0;
        v1        <= 1'b0;
        drain     <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/aess_fifo.sv
`default_nettype none
module aess_fifo import aess_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  token_t      in_tok,
  input  wire logic   in_valid,
  output logic        in_ready,
  output token_t      out_tok,
  output logic        out_valid,
  input  wire logic   out_ready
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               wr_en;
  logic               rd_en;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_tok   = slots[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/aess_gap.sv
`default_nettype none
module aess_gap import aess_pkg::*; #(
  parameter int RUN = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  token_t      in_tok,
  input  wire logic   in_valid,
  output logic        in_ready,
  output token_t      out_tok,
  output logic        out_valid,
  input  wire logic   out_ready
);

  level_t       win [RUN+1];
  level_t       filled [RUN+1];
  logic [RUN:0] vld;
  logic         drain;

  logic all_low;
  logic fill;
  logic tail_empty;
  logic out_free;
  logic accept;
  logic drain_go;

  // a run of exactly RUN levels below top, bounded by top on both sides
  always_comb begin
    all_low = 1'b1;
    for (int i = 1; i <= RUN; i++) begin
      all_low = all_low && (win[i] < LVL_TOP);
    end
    fill = vld[0] && (win[0] == LVL_TOP) && all_low && (in_tok.level == LVL_TOP);
    filled[0] = win[0];
    for (int i = 1; i <= RUN; i++) begin
      filled[i] = fill ? LVL_TOP : win[i];
    end
  end

  assign tail_empty = ~|vld[RUN:2];
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = !drain && out_free;
  assign accept     = in_valid && in_ready;
  assign drain_go   = drain && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (vld[1]) begin
          out_tok   <= '{level: filled[1], last: 1'b0};
          out_valid <= 1'b1;
        end
        for (int i = 0; i < RUN; i++) begin
          win[i] <= filled[i+1];
        end
        win[RUN] <= in_tok.level;
        vld      <= {1'b1, vld[RUN:1]};
        drain    <= in_tok.last;
      end else if (drain_go) begin
        // end of day: shift the held levels out with no further filling
        for (int i = 0; i < RUN; i++) begin
          win[i] <= win[i+1];
        end
        vld <= {1'b0, vld[RUN:1]};
        if (vld[1]) begin
          out_tok   <= '{level: win[1], last: tail_empty};
          out_valid <= 1'b1;
          if (tail_empty) begin
            vld   <= '0;
            drain <= 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/aess_stager.sv
`default_nettype none
module aess_stager import aess_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  token_t      in_tok,
  input  wire logic   in_valid,
  output logic        in_ready,
  output stage_t      stage,
  output logic [7:0]  epoch_index,
  output logic        final_res,
  output logic        out_valid,
  input  wire logic   out_ready
);

  level_t     w0;
  level_t     w1;
  logic       v0;
  logic       v1;
  logic       drain;
  logic [7:0] cnt;

  logic out_free;
  logic accept;
  logic drain_go;

  function automatic stage_t classify(input level_t lv, input logic interior,
                                      input level_t left, input level_t right);
    stage_t s;
    if (lv == LVL_ZERO) begin
      s = (interior && (left != LVL_ZERO || right != LVL_ZERO)) ? STAGE_SHALLOW
                                                                : STAGE_DEEP;
    end else if (lv == LVL_LOW) begin
      s = STAGE_SHALLOW;
    end else begin
      s = STAGE_ACTIVE;
    end
    return s;
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = !drain && out_free;
  assign accept   = in_valid && in_ready;
  assign drain_go = drain && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      drain     <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (v1) begin
          stage       <= classify(w1, v0, w0, in_tok.level);
          epoch_index <= cnt;
          final_res   <= 1'b0;
          out_valid   <= 1'b1;
          cnt         <= cnt + 1'b1;
          w0          <= w1;
          v0          <= 1'b1;
        end
        w1    <= in_tok.level;
        v1    <= 1'b1;
        drain <= in_tok.last;
      end else if (drain_go) begin
        // last epoch of the day has no right neighbour
        stage       <= classify(w1, 1'b0, w0, w1);
        epoch_index <= cnt;
        final_res   <= 1'b1;
        out_valid   <= 1'b1;
        cnt         <= '0;
        v0          <= 1'b0;
        v1          <= 1'b0;
        drain       <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/activity_epoch_sleep_stager_unit.sv
`default_nettype none
// channel   direction  handshake          payload
// input     in         push / full        activity, last
// result    out        pop / empty        stage, epoch_index, final_res
//
// one epoch accepted per cycle while full is low; each pass (dip smoothing,
// two- and three-epoch fills, staging) is a short register window with its own
// output register. a result appears seven epochs after its own epoch; the day's
// last epoch flushes the windows, each pass stalling its input while it shifts
// out what it holds. a four-entry queue sits between the smoothing front and
// the fill/staging back. rst is synchronous and returns every window to empty
// and the day counters to zero.
module activity_epoch_sleep_stager_unit import aess_pkg::*; #(
  parameter int MAX_EPOCHS    = 256,
  parameter int ACTIVITY_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ACTIVITY_BITS-1:0] activity,
  input  wire logic                     last,
  input  wire logic                     push,
  output logic                          full,
  output logic [1:0]                    stage,
  output logic [7:0]                    epoch_index,
  output logic                          final_res,
  output logic                          empty,
  input  wire logic                     pop
);

  token_t front_tok;
  logic   front_valid;
  logic   front_ready;
  token_t q_tok;
  logic   q_valid;
  logic   q_ready;
  token_t two_tok;
  logic   two_valid;
  logic   two_ready;
  token_t three_tok;
  logic   three_valid;
  logic   three_ready;
  logic   in_ready;
  logic   res_valid;
  stage_t res_stage;

  aess_front #(
    .MAX_EPOCHS    (MAX_EPOCHS),
    .ACTIVITY_BITS (ACTIVITY_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .activity  (activity),
    .last      (last),
    .in_valid  (push),
    .in_ready  (in_ready),
    .out_tok   (front_tok),
    .out_valid (front_valid),
    .out_ready (front_ready)
  );

  aess_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_tok    (front_tok),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_tok   (q_tok),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  aess_gap #(
    .RUN (2)
  ) u_gap_two (
    .clk       (clk),
    .rst       (rst),
    .in_tok    (q_tok),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .out_tok   (two_tok),
    .out_valid (two_valid),
    .out_ready (two_ready)
  );

  aess_gap #(
    .RUN (3)
  ) u_gap_three (
    .clk       (clk),
    .rst       (rst),
    .in_tok    (two_tok),
    .in_valid  (two_valid),
    .in_ready  (two_ready),
    .out_tok   (three_tok),
    .out_valid (three_valid),
    .out_ready (three_ready)
  );

  aess_stager u_stager (
    .clk         (clk),
    .rst         (rst),
    .in_tok      (three_tok),
    .in_valid    (three_valid),
    .in_ready    (three_ready),
    .stage       (res_stage),
    .epoch_index (epoch_index),
    .final_res   (final_res),
    .out_valid   (res_valid),
    .out_ready   (pop)
  );

  assign full  = !in_ready;
  assign empty = !res_valid;
  assign stage = res_stage;

endmodule
`default_nettype wire

### test/activity_epoch_sleep_stager_unit_tb.sv
`default_nettype none
module activity_epoch_sleep_stager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aess_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 40;
  localparam int DAY_MAX      = 256;
  localparam int RANDOM_ITEMS = 335;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 600;

  localparam level_t LVL_160 = 3'd2;
  localparam level_t LVL_240 = 3'd3;
  localparam level_t LVL_320 = 3'd4;

  typedef struct {
    logic [15:0] act;
    logic        lst;
    int          gap;
    bit          drain;
  } epoch_t;

  typedef struct {
    stage_t     stg;
    logic [7:0] idx;
    logic       fin;
  } staged_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] activity = '0;
  logic        last = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  wire         full;
  wire         empty;
  wire  [1:0]  stage;
  wire  [7:0]  epoch_index;
  wire         final_res;

  activity_epoch_sleep_stager_unit dut (
    .clk(clk),
    .rst(rst),
    .activity(activity),
    .last(last),
    .push(push),
    .full(full),
    .stage(stage),
    .epoch_index(epoch_index),
    .final_res(final_res),
    .empty(empty),
    .pop(pop)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  epoch_t  epoch_queue[$];
  staged_t due_stages[$];

  int     cyc = 0;
  int     n_results = 0;
  bit     failed = 1'b0;
  bit     in_xfer = 1'b0;
  bit     out_xfer = 1'b0;
  bit     holding = 1'b0;
  int     tx_wait = 0;
  epoch_t cur_epoch;
  int     rx_wait = 0;
  bit     rx_calm = 1'b0;

  // stager state: smoothing, two-gap fill, three-gap fill, staging windows
  level_t      smooth_w[2];
  level_t      fill2_w[3];
  level_t      fill3_w[4];
  level_t      stage_w[2];
  logic [10:0] slot_full;
  logic [7:0]  next_index;
  int          day_len;

  function automatic void clear_day();
    smooth_w   = '{default: LVL_ZERO};
    fill2_w    = '{default: LVL_ZERO};
    fill3_w    = '{default: LVL_ZERO};
    stage_w    = '{default: LVL_ZERO};
    slot_full  = '0;
    next_index = '0;
    day_len    = 0;
  endfunction

  function automatic level_t level_of(logic [15:0] a);
    if (a >= 320) return LVL_TOP;
    if (a >= 240) return LVL_320;
    if (a >= 160) return LVL_240;
    if (a > 80) return LVL_160;
    if (a > 0) return LVL_LOW;
    return LVL_ZERO;
  endfunction

  function automatic level_t to_sleep_level(level_t c);
    return (c > LVL_LOW) ? LVL_TOP : c;
  endfunction

  function automatic stage_t stage_of(level_t c, bit interior, level_t left, level_t right);
    if (c == LVL_ZERO)
      return (interior && (left != LVL_ZERO || right != LVL_ZERO)) ? STAGE_SHALLOW : STAGE_DEEP;
    if (c == LVL_LOW) return STAGE_SHALLOW;
    return STAGE_ACTIVE;
  endfunction

  function automatic void emit_stage(stage_t s, logic f);
    staged_t item;
    item.stg = s;
    item.idx = next_index;
    item.fin = f;
    due_stages.insert(due_stages.size(), item);
    next_index++;
  endfunction

  function automatic void stage_in(level_t x);
    if (slot_full[10]) emit_stage(stage_of(stage_w[1], slot_full[9], stage_w[0], x), 1'b0);
    stage_w[0] = stage_w[1];
    if (slot_full[10]) slot_full[9] = 1'b1;
    stage_w[1] = x;
    slot_full[10] = 1'b1;
  endfunction

  function automatic void fill3_in(level_t x);
    if (slot_full[5] && fill3_w[0] == LVL_TOP && fill3_w[1] < LVL_TOP &&
        fill3_w[2] < LVL_TOP && fill3_w[3] < LVL_TOP && x == LVL_TOP) begin
      fill3_w[1] = LVL_TOP;
      fill3_w[2] = LVL_TOP;
      fill3_w[3] = LVL_TOP;
    end
    if (slot_full[6]) stage_in(fill3_w[1]);
    fill3_w[0] = fill3_w[1];
    fill3_w[1] = fill3_w[2];
    fill3_w[2] = fill3_w[3];
    fill3_w[3] = x;
    slot_full[7:5] = slot_full[8:6];
    slot_full[8] = 1'b1;
  endfunction

  function automatic void fill2_in(level_t x);
    if (slot_full[2] && fill2_w[0] == LVL_TOP && fill2_w[1] < LVL_TOP &&
        fill2_w[2] < LVL_TOP && x == LVL_TOP) begin
      fill2_w[1] = LVL_TOP;
      fill2_w[2] = LVL_TOP;
    end
    if (slot_full[3]) fill3_in(fill2_w[1]);
    fill2_w[0] = fill2_w[1];
    fill2_w[1] = fill2_w[2];
    fill2_w[2] = x;
    slot_full[3:2] = slot_full[4:3];
    slot_full[4] = 1'b1;
  endfunction

  function automatic void smooth_in(level_t x);
    level_t c;
    level_t p;
    if (slot_full[1]) begin
      c = smooth_w[1];
      if (slot_full[0]) begin
        p = smooth_w[0];
        // p is the already smoothed previous level, x the next one
        if (p == x && c < p) c = p;
        else if (int'(p) == int'(x) + 1 && c < x) c = x;
        else if (int'(x) == int'(p) + 1 && c < p) c = p;
      end
      fill2_in(to_sleep_level(c));
      smooth_w[0] = c;
      slot_full[0] = 1'b1;
    end
    smooth_w[1] = x;
    slot_full[1] = 1'b1;
  endfunction

  function automatic void predict_epoch(logic [15:0] a, logic l);
    day_len++;
    smooth_in(level_of(a));
    // a day that reaches its maximum length closes without last
    if (l || day_len >= DAY_MAX) begin
      if (slot_full[1]) fill2_in(to_sleep_level(smooth_w[1]));
      for (int i = 1; i < 3; i++)
        if (slot_full[2+i]) fill3_in(fill2_w[i]);
      for (int i = 1; i < 4; i++)
        if (slot_full[5+i]) stage_in(fill3_w[i]);
      if (slot_full[10]) emit_stage(stage_of(stage_w[1], 1'b0, LVL_ZERO, LVL_ZERO), 1'b1);
      clear_day();
    end
  endfunction

  // transfers are taken and checked here
  always @(posedge clk) begin
    staged_t want;
    cyc = cyc + 1;
    in_xfer = 1'b0;
    out_xfer = 1'b0;
    if (rst) begin
      clear_day();
    end else begin
      if (push && !full) begin
        in_xfer = 1'b1;
        predict_epoch(activity, last);
      end
      if (pop && !empty) begin
        out_xfer = 1'b1;
        n_results++;
        if (due_stages.size() == 0) begin
          $display("%0t: unexpected result stage %0d index %0d final %0b",
                   $time, stage, epoch_index, final_res);
          failed = 1'b1;
        end else begin
          want = due_stages.pop_front();
          if (stage !== want.stg || epoch_index !== want.idx || final_res !== want.fin) begin
            $display("%0t: expected stage %0d index %0d final %0b, actual stage %0d index %0d final %0b",
                     $time, want.stg, want.idx, want.fin, stage, epoch_index, final_res);
            failed = 1'b1;
          end
        end
      end
    end
    if (cyc >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    bit offer;
    rst <= (cyc < RESET_CYCLES);
    offer = push && !in_xfer;
    if (!offer && cyc >= RESET_CYCLES) begin
      if (!holding && epoch_queue.size() > 0) begin
        cur_epoch = epoch_queue.pop_front();
        holding = 1'b1;
        tx_wait = cur_epoch.gap;
      end
      if (holding) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (!cur_epoch.drain || due_stages.size() == 0) begin
          activity <= cur_epoch.act;
          last <= cur_epoch.lst;
          offer = 1'b1;
          holding = 1'b0;
        end
      end
    end
    push <= offer;
  end

  // receiver
  always @(negedge clk) begin
    bit take;
    if (out_xfer) begin
      if (n_results == HOLD_AT) rx_wait = HOLD_CYCLES;
      else rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
    end
    take = pop && !out_xfer;
    if (!take && cyc >= RESET_CYCLES) begin
      if (rx_wait > 0) rx_wait--;
      else take = 1'b1;
    end
    pop <= take;
  end

  task automatic queue_epoch(logic [15:0] a, logic l, int gap, bit drain);
    epoch_t item;
    item.act   = a;
    item.lst   = l;
    item.gap   = gap;
    item.drain = drain;
    epoch_queue.insert(epoch_queue.size(), item);
  endtask

  function automatic logic [15:0] pick_activity();
    logic [15:0] edges[9];
    edges = '{16'd79, 16'd80, 16'd81, 16'd159, 16'd160, 16'd239, 16'd240, 16'd319, 16'd320};
    case ($urandom_range(0, 9))
      0, 1:    return 16'd0;
      2, 3:    return 16'($urandom_range(1, 80));
      4:       return 16'($urandom_range(81, 319));
      5:       return edges[$urandom_range(0, 8)];
      6, 7:    return 16'($urandom_range(320, 600));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int          n_rand;
    int          len;
    int          seg_left;
    bit          calm;
    bit          pattern;
    bit          long_done;
    bit          first_day;
    logic [15:0] a;

    // edges, single and short days, fills, dips, interior zeros
    queue_epoch(16'd0, 1'b1, 0, 1'b0);
    queue_epoch(16'd65535, 1'b1, 1, 1'b0);
    queue_epoch(16'd80, 1'b0, 0, 1'b0);
    queue_epoch(16'd0, 1'b1, 2, 1'b0);
    queue_epoch(16'd400, 1'b0, 0, 1'b0);
    queue_epoch(16'd0, 1'b0, 0, 1'b0);
    queue_epoch(16'd0, 1'b0, 0, 1'b0);
    queue_epoch(16'd400, 1'b1, 0, 1'b0);
    queue_epoch(16'd400, 1'b0, 3, 1'b0);
    queue_epoch(16'd50, 1'b0, 0, 1'b0);
    queue_epoch(16'd50, 1'b0, 1, 1'b0);
    queue_epoch(16'd50, 1'b0, 0, 1'b0);
    queue_epoch(16'd400, 1'b0, 0, 1'b0);
    queue_epoch(16'd0, 1'b1, 0, 1'b0);
    queue_epoch(16'd240, 1'b0, 0, 1'b0);
    queue_epoch(16'd100, 1'b0, 0, 1'b0);
    queue_epoch(16'd240, 1'b0, 0, 1'b0);
    queue_epoch(16'd319, 1'b0, 0, 1'b0);
    queue_epoch(16'd159, 1'b0, 0, 1'b0);
    queue_epoch(16'd160, 1'b0, 0, 1'b0);
    queue_epoch(16'd81, 1'b0, 0, 1'b0);
    queue_epoch(16'd1, 1'b1, 0, 1'b0);
    queue_epoch(16'd0, 1'b0, 0, 1'b0);
    queue_epoch(16'd0, 1'b0, 0, 1'b0);
    queue_epoch(16'd30, 1'b1, 0, 1'b0);

    n_rand = 0;
    long_done = 1'b0;
    first_day = 1'b1;
    while (n_rand < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 2) == 0);
      pattern = ($urandom_range(0, 1) == 1);
      seg_left = 0;
      if (!long_done && n_rand >= 50) begin
        // overlong day with no last, closed by the length limit
        len = DAY_MAX;
        long_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 5);
      end else begin
        len = $urandom_range(6, 24);
      end
      for (int k = 0; k < len; k++) begin
        if (pattern && seg_left == 0) begin
          a = 16'($urandom_range(320, 2000));
          seg_left = $urandom_range(1, 4);
        end else begin
          a = pattern ? 16'($urandom_range(0, 80)) : pick_activity();
          if (seg_left > 0) seg_left--;
        end
        queue_epoch(a, (k == len - 1) && (len != DAY_MAX),
                    calm ? 0 : $urandom_range(0, 15),
                    (k == 0) && (first_day || $urandom_range(0, 5) == 0));
        first_day = 1'b0;
      end
      n_rand += len;
    end

    while (epoch_queue.size() != 0 || holding || push) @(posedge clk);
    while (due_stages.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hw/rtl/aess_pkg.sv
hw/rtl/aess_front.sv
hw/rtl/aess_fifo.sv
hw/rtl/aess_gap.sv
hw/rtl/aess_stager.sv
hw/rtl/activity_epoch_sleep_stager_unit.sv
test/activity_epoch_sleep_stager_unit_tb.sv
